@@ hdl/lbp_pkg.sv @@
// Shared types, widths and helpers for the LSB-first bit packer.
`timescale 1ns / 1ps

package lbp_pkg;

    localparam int VALUE_W = 62;  // element width on the input
    localparam int WIDTH_W = 6;   // element width register
    localparam int PEND_W  = 7;   // pending bits kept between elements
    localparam int CNT_W   = 3;   // pending bit count
    localparam int BYTE_W  = 8;
    localparam int ACC_W   = 72;  // pending bits plus one element, whole bytes
    localparam int NBYTE_W = 4;   // bytes in one chunk, up to nine
    localparam int TOTAL_W = 7;   // pending count plus element width
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 8;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(8);

    // One element's worth of finished bytes, waiting to be sent
    typedef struct packed {
        logic [ACC_W-1:0]   word;
        logic [NBYTE_W-1:0] nbytes;
        logic               last;
    } t_chunk;

    // Mask that keeps the low w bits of an element
    function automatic logic [VALUE_W-1:0] value_mask(input logic [WIDTH_W-1:0] w);
        logic [WIDTH_W+VALUE_W-1:0] ones;
        ones = ({{(WIDTH_W+VALUE_W-1){1'b0}}, 1'b1} << w) - 1'b1;
        if (w >= WIDTH_W'(VALUE_W)) begin
            value_mask = '1;
        end else begin
            value_mask = ones[VALUE_W-1:0];
        end
    endfunction

endpackage

@@ hdl/lbp_merge.sv @@
// Merges each element with the pending bits and queues the completed bytes.
`timescale 1ns / 1ps

module lbp_merge (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic [lbp_pkg::WIDTH_W-1:0]  i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [lbp_pkg::VALUE_W-1:0]  i_value,
    input  logic                         i_last,
    output logic                         o_slot_vld,
    output lbp_pkg::t_chunk              o_slot,
    input  logic                         i_slot_take
);

    logic [lbp_pkg::WIDTH_W-1:0] r_elem_width;
    logic [lbp_pkg::PEND_W-1:0]  r_pend, n_pend;
    logic [lbp_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic                        r_slot_vld;
    lbp_pkg::t_chunk             r_slot, n_slot;

    logic [lbp_pkg::VALUE_W-1:0] v_masked;
    logic [lbp_pkg::ACC_W-1:0]   acc;
    logic [lbp_pkg::ACC_W-1:0]   acc_rest;
    logic [lbp_pkg::TOTAL_W-1:0] total;
    logic [lbp_pkg::NBYTE_W-1:0] full_bytes;
    logic                        accept;

    // Take a request when the queue slot is free or drains this cycle
    assign o_ready = !r_slot_vld || i_slot_take;
    assign accept  = i_valid && o_ready;

    // Join pending bits below the masked element and count the bytes
    always_comb begin
        v_masked   = i_value & lbp_pkg::value_mask(r_elem_width);
        acc        = lbp_pkg::ACC_W'(r_pend)
                   | (lbp_pkg::ACC_W'(v_masked) << r_cnt);
        total      = lbp_pkg::TOTAL_W'(r_cnt) + lbp_pkg::TOTAL_W'(r_elem_width);
        full_bytes = total[lbp_pkg::TOTAL_W-1:3];
        acc_rest   = acc >> {full_bytes, 3'b000};

        n_slot.word   = acc;
        n_slot.last   = i_last;
        n_slot.nbytes = full_bytes;
        if (i_last && (total[2:0] != 3'd0)) begin
            n_slot.nbytes = full_bytes + 1'b1;
        end

        // Clear the pending state on a flush, otherwise keep the leftover for the next element
        if (i_last) begin
            n_pend = '0;
            n_cnt  = '0;
        end else begin
            n_pend = acc_rest[lbp_pkg::PEND_W-1:0];
            n_cnt  = total[2:0];
        end
    end

    // Hold the width register, the pending state and the slot valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_width <= lbp_pkg::WIDTH_RESET;
            r_pend       <= '0;
            r_cnt        <= '0;
            r_slot_vld   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_elem_width <= i_cfg_data;
            end
            if (accept) begin
                r_pend <= n_pend;
                r_cnt  <= n_cnt;
            end
            if (accept && (n_slot.nbytes != '0)) begin
                r_slot_vld <= 1'b1;
            end else if (i_slot_take) begin
                r_slot_vld <= 1'b0;
            end
        end
    end

    // Load the queued chunk
    always_ff @(posedge i_clk) begin
        if (accept && (n_slot.nbytes != '0)) begin
            r_slot <= n_slot;
        end
    end

    assign o_slot_vld = r_slot_vld;
    assign o_slot     = r_slot;

endmodule

@@ hdl/lbp_emit.sv @@
// Sends a queued chunk out one byte per cycle while the output is ready, lowest byte first.
`timescale 1ns / 1ps

module lbp_emit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_slot_vld,
    input  lbp_pkg::t_chunk               i_slot,
    output logic                          o_slot_take,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [lbp_pkg::BYTE_W-1:0]    o_byte,
    output logic                          o_last
);

    logic [lbp_pkg::ACC_W-1:0]   r_word;
    logic [lbp_pkg::NBYTE_W-1:0] r_left;
    logic                        r_last;
    logic                        take;
    logic                        load;

    assign o_valid = (r_left != '0);
    assign take    = o_valid && i_ready;
    // Pull the next chunk when idle or when the final byte leaves now
    assign load    = i_slot_vld
                   && ((r_left == '0) || ((r_left == lbp_pkg::NBYTE_W'(1)) && i_ready));
    assign o_slot_take = load;

    // Advance the byte count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (load) begin
            r_left <= i_slot.nbytes;
        end else if (take) begin
            r_left <= r_left - 1'b1;
        end
    end

    // Shift the word down one byte per request
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word <= i_slot.word;
            r_last <= i_slot.last;
        end else if (take) begin
            r_word <= r_word >> lbp_pkg::BYTE_W;
        end
    end

    assign o_byte = r_word[lbp_pkg::BYTE_W-1:0];
    assign o_last = r_last && (r_left == lbp_pkg::NBYTE_W'(1));

endmodule

@@ hdl/lsb_first_bit_packer.sv @@
// Top level of the LSB-first variable-width bit packer.
`timescale 1ns / 1ps

// Packs elements of a programmable width (register, reset 8) densely into bytes,
// least significant bit first, carrying up to seven leftover bits between
// elements. An element's completed bytes (zero to nine) go into a one-chunk
// queue and leave one byte per cycle while the output is ready, so the output
// channel sets the sustained rate. A new element is accepted while the
// previous chunk is still being sent, as long as the queue slot is free or
// empties that cycle. An element flagged tlast flushes any partial byte
// zero-padded and marks the final byte, if any, with tlast.
// Write the width register only while the block is idle.
module lsb_first_bit_packer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lbp_pkg::WIDTH_W-1:0]        i_cfg_data,     // element width
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [lbp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [61:0] value, rest zero
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [lbp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // [7:0] out_byte
    output logic                               m_axis_tlast
);

    logic            slot_vld;
    logic            slot_take;
    lbp_pkg::t_chunk slot;

    assign o_cfg_ready = 1'b1;

    lbp_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_value     (s_axis_tdata[lbp_pkg::VALUE_W-1:0]),
        .i_last      (s_axis_tlast),
        .o_slot_vld  (slot_vld),
        .o_slot      (slot),
        .i_slot_take (slot_take)
    );

    lbp_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_slot_vld  (slot_vld),
        .i_slot      (slot),
        .o_slot_take (slot_take),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_byte      (m_axis_tdata),
        .o_last      (m_axis_tlast)
    );

endmodule

@@ tb/lsb_first_bit_packer_tb.sv @@
// Self-checking testbench for the LSB-first bit packer: stream stimulus and byte scoreboard.
`timescale 1ns / 1ps

// One packed byte as it leaves the block
typedef struct packed {
    logic [lbp_pkg::BYTE_W-1:0] data;
    logic                       last;
} t_packed_byte;

// Tracks the packer's carry state and the bytes it still owes
class byte_scoreboard;
    logic [lbp_pkg::WIDTH_W-1:0] width;
    logic [lbp_pkg::PEND_W-1:0]  held_bits;
    logic [lbp_pkg::CNT_W-1:0]   held_count;
    t_packed_byte                owed_q[$];
    int                          errors;

    function new();
        width      = lbp_pkg::WIDTH_RESET;
        held_bits  = '0;
        held_count = '0;
        errors     = 0;
    endfunction

    function void set_width(input logic [lbp_pkg::WIDTH_W-1:0] w);
        width = w;
    endfunction

    // Append the carried bits and one element, then split off every whole byte
    function void note_element(input logic [lbp_pkg::VALUE_W-1:0] value, input logic last);
        logic [lbp_pkg::ACC_W-1:0]   acc;
        logic [lbp_pkg::VALUE_W-1:0] kept;
        t_packed_byte                b;
        int                          total;
        int                          k;
        int                          n;
        kept = value;
        for (k = 0; k < lbp_pkg::VALUE_W; k++) begin
            if (k >= int'(width)) begin
                kept[k] = 1'b0;
            end
        end
        // held bits above the count are always zero here
        acc   = lbp_pkg::ACC_W'(held_bits) | (lbp_pkg::ACC_W'(kept) << held_count);
        total = int'(held_count) + int'(width);
        n     = 0;
        while (total >= lbp_pkg::BYTE_W) begin
            b.data = acc[lbp_pkg::BYTE_W-1:0];
            b.last = 1'b0;
            owed_q = {owed_q, b};
            acc   = acc >> lbp_pkg::BYTE_W;
            total = total - lbp_pkg::BYTE_W;
            n++;
        end
        if (last) begin
            if (total > 0) begin
                // flush the partial byte, zero padded
                b.data = acc[lbp_pkg::BYTE_W-1:0] & ((8'd1 << total) - 8'd1);
                b.last = 1'b1;
                owed_q = {owed_q, b};
            end else if (n > 0) begin
                // vector ends on a byte boundary: flag the byte just completed
                owed_q[owed_q.size()-1].last = 1'b1;
            end
            held_bits  = '0;
            held_count = '0;
        end else begin
            held_bits  = acc[lbp_pkg::PEND_W-1:0];
            held_count = lbp_pkg::CNT_W'(total);
        end
    endfunction

    // Compare one output byte with the oldest owed byte
    function void check_byte(input logic [lbp_pkg::BYTE_W-1:0] data, input logic last);
        t_packed_byte b;
        if (owed_q.size() == 0) begin
            $error("unexpected byte: out_byte %0h last_byte %0b", data, last);
            errors++;
        end else begin
            b = owed_q.pop_front();
            if (data !== b.data) begin
                $error("out_byte: expected %0h, actual %0h", b.data, data);
                errors++;
            end
            if (last !== b.last) begin
                $error("last_byte: expected %0b, actual %0b", b.last, last);
                errors++;
            end
        end
    endfunction
endclass

module lsb_first_bit_packer_tb;

    localparam int CLK_HALF = 5;
    localparam int RESET_CYCLES = 8;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASES = 10;
    localparam int PHASE_ITEMS = 36;
    localparam logic [lbp_pkg::VALUE_W-1:0] ALL_ONES = {lbp_pkg::VALUE_W{1'b1}};

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [lbp_pkg::WIDTH_W-1:0]     i_cfg_data = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [lbp_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [61:0] value, rest zero
    logic                            s_axis_tlast = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [lbp_pkg::OUT_TDATA_W-1:0] m_axis_tdata;         // [7:0] out_byte
    logic                            m_axis_tlast;

    byte_scoreboard sb;
    bit             calm = 1'b0;
    int             gap_odds = 0;
    int             stall_left = 0;
    int             stall_odds = 2;
    int             window = 0;
    int             cycles = 0;

    lsb_first_bit_packer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Free-running clock
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Observe every handshake: config first, then input, then output
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                sb.set_width(i_cfg_data);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_element(s_axis_tdata[lbp_pkg::VALUE_W-1:0], s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_byte(m_axis_tdata, m_axis_tlast);
            end
        end
    end

    // Stall the output in random bursts; the stall rate is redrawn at the end of each window
    always @(posedge i_clk) begin
        window++;
        if (window == 64) begin
            window = 0;
            stall_odds = $urandom_range(0, 3);
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (!calm && stall_odds != 0 && $urandom_range(1, 4 * stall_odds) == 1) begin
            stall_left = $urandom_range(0, 13);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Abort a run that hangs
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("lsb_first_bit_packer_tb: errors");
        $finish;
    end

    // Issue one element request, with an optional idle burst ahead of it
    task automatic push_element(input logic [lbp_pkg::VALUE_W-1:0] value, input logic last);
        if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= lbp_pkg::IN_TDATA_W'(value);
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Hold the input until every owed byte is out and the block has settled
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.owed_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the width register while the block is idle
    task automatic write_width(input logic [lbp_pkg::WIDTH_W-1:0] w);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [lbp_pkg::VALUE_W-1:0] pick_value();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       pick_value = '0;
            1:       pick_value = ALL_ONES;
            2:       pick_value = lbp_pkg::VALUE_W'(1)
                                  << $urandom_range(0, lbp_pkg::VALUE_W - 1);
            default: pick_value = r[lbp_pkg::VALUE_W-1:0];
        endcase
    endfunction

    function automatic logic [lbp_pkg::WIDTH_W-1:0] pick_width(input int phase);
        case (phase)
            0:       pick_width = lbp_pkg::WIDTH_W'(1);
            1:       pick_width = lbp_pkg::WIDTH_W'(63);
            2:       pick_width = lbp_pkg::WIDTH_W'(0);
            3:       pick_width = lbp_pkg::WIDTH_W'(62);
            default: pick_width = lbp_pkg::WIDTH_W'($urandom_range(1, 62));
        endcase
    endfunction

    initial begin
        int phase;
        int k;
        int run_left;
        logic last;
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        gap_odds = 3;

        // Reset width of eight, including masking and a last on a full byte
        push_element(lbp_pkg::VALUE_W'(8'hA5), 1'b0);
        push_element(ALL_ONES, 1'b1);

        // Leave six bits pending, then flush them with a width-zero last
        write_width(lbp_pkg::WIDTH_W'(3));
        push_element(lbp_pkg::VALUE_W'(5), 1'b0);
        push_element(lbp_pkg::VALUE_W'(2), 1'b0);
        write_width(lbp_pkg::WIDTH_W'(0));
        push_element(ALL_ONES, 1'b1);

        // Width zero with nothing pending: a last produces no byte
        push_element(ALL_ONES, 1'b0);
        push_element('0, 1'b1);

        // Single-bit elements with junk above bit zero, partial flush at the end
        write_width(lbp_pkg::WIDTH_W'(1));
        for (k = 0; k < 8; k++) begin
            push_element(ALL_ONES ^ lbp_pkg::VALUE_W'(k % 3 == 1), 1'b0);
        end
        push_element(ALL_ONES, 1'b1);

        // Elements as wide as the value field
        write_width(lbp_pkg::WIDTH_W'(62));
        push_element(ALL_ONES, 1'b0);
        push_element('0, 1'b0);
        push_element({(lbp_pkg::VALUE_W / 2){2'b10}}, 1'b1);
        push_element({(lbp_pkg::VALUE_W / 2){2'b01}}, 1'b1);

        // Width sixty-three: the top element bit is never set
        write_width(lbp_pkg::WIDTH_W'(63));
        push_element(ALL_ONES, 1'b1);
        push_element(lbp_pkg::VALUE_W'(1) << (lbp_pkg::VALUE_W - 1), 1'b1);

        // A width just off a byte
        write_width(lbp_pkg::WIDTH_W'(9));
        push_element(lbp_pkg::VALUE_W'(9'h1FF), 1'b0);
        push_element(lbp_pkg::VALUE_W'(9'h100), 1'b1);

        // Random phases of vectors with random content and a few broken ones
        for (phase = 0; phase < PHASES; phase++) begin
            write_width(pick_width(phase));
            calm = (phase >= PHASES - 2);
            case ($urandom_range(0, 2))
                0:       gap_odds = 0;
                1:       gap_odds = 4;
                default: gap_odds = 2;
            endcase
            run_left = $urandom_range(1, 10);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                run_left--;
                if ($urandom_range(0, 9) == 0) begin
                    last = 1'($urandom);
                end else begin
                    last = (run_left == 0);
                end
                if (run_left <= 0) begin
                    run_left = $urandom_range(1, 10);
                end
                push_element(pick_value(), last);
            end
        end

        // Wait out the tail and report
        drain();
        if (sb.owed_q.size() != 0) begin
            $error("bytes never produced: %0d", sb.owed_q.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("lsb_first_bit_packer_tb: clean");
        end else begin
            $display("lsb_first_bit_packer_tb: errors");
        end
        $finish;
    end

endmodule

@@ lsb_first_bit_packer.f @@
hdl/lbp_pkg.sv
hdl/lbp_merge.sv
hdl/lbp_emit.sv
hdl/lsb_first_bit_packer.sv
tb/lsb_first_bit_packer_tb.sv
